// ----- hw/rtl/serial_line_editor_macros.svh -----
// Assertion macros for the serial line editor.
`ifndef SERIAL_LINE_EDITOR_MACROS_SVH
`define SERIAL_LINE_EDITOR_MACROS_SVH

`ifndef SYNTHESIS
`define SLE_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
`define SLE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define SLE_ASSERT_IMPLY(label, clk, rst, cond, expr, msg)
`define SLE_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`endif

`endif

// ----- hw/rtl/sle_pkg.sv -----
package sle_pkg;

  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_DEL      = 8'h7f;
  localparam logic [7:0] CHAR_ESC      = 8'h1b;
  localparam logic [7:0] CHAR_CARET    = 8'h5e;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
  localparam logic [7:0] CHAR_CR       = 8'h0d;
  localparam logic [7:0] CHAR_LF       = 8'h0a;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       end_of_line;
    logic [6:0] line_length;
    logic [7:0] read_data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic nonempty;
    logic room1;
    logic room2;
  } line_status_t;

  typedef struct packed {
    logic       clr;
    logic       dec;
    logic       store1;
    logic       store2;
    logic [7:0] store_data;
    logic       echo0_valid;
    logic [7:0] echo0_byte;
    logic       two;
    logic [7:0] echo1_byte;
    logic       eol;
    logic       is_read;
  } action_t;

endpackage

// ----- hw/rtl/sle_decode.sv -----
module sle_decode
  import sle_pkg::*;
(
  input  item_t        item,
  input  line_status_t status,
  output action_t      action
);

  always_comb begin
    action = '0;
    unique case (item.kind)
      KIND_CLEAR: begin
        action.clr = 1'b1;
      end
      KIND_READ: begin
        action.is_read = 1'b1;
      end
      KIND_RX: begin
        case (item.rx_byte) inside
          CHAR_BS, CHAR_DEL: begin
            if (status.nonempty) begin
              action.dec         = 1'b1;
              action.echo0_valid = 1'b1;
              action.echo0_byte  = item.rx_byte;
            end
          end
          CHAR_ESC: begin
            if (status.room1) begin
              action.store1      = 1'b1;
              action.store_data  = CHAR_CARET;
              action.echo0_valid = 1'b1;
              action.echo0_byte  = CHAR_CARET;
              if (status.room2) begin
                action.store2     = 1'b1;
                action.two        = 1'b1;
                action.echo1_byte = CHAR_LBRACKET;
              end
            end
          end
          CHAR_LF: begin
          end
          CHAR_CR: begin
            action.echo0_valid = 1'b1;
            action.echo0_byte  = CHAR_CR;
            action.two         = 1'b1;
            action.echo1_byte  = CHAR_LF;
            action.eol         = 1'b1;
          end
          default: begin
            if (status.room1) begin
              action.store1      = 1'b1;
              action.store_data  = item.rx_byte;
              action.echo0_valid = 1'b1;
              action.echo0_byte  = item.rx_byte;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/serial_line_editor.sv -----
// The input word is registered in s1, then processed into the result register.
// Throughput: one input word per cycle for single-result words while result_ready
// is held; words that give two results (carriage return, escape with room for both
// characters) are presented one after the other by the single result register.
// Reset: synchronous; clears the line length and all valid flags, store contents undefined.
`include "serial_line_editor_macros.svh"

module serial_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(LINE_CAPACITY + 1);

  logic          s1_valid;
  item_t         s1;
  logic          proc_fire;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW:0]   count_p1;
  line_status_t  status;
  action_t       action;

  logic [7:0]    line_store [LINE_CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] rd_addr;
  logic [AW+5:0] idx_wide;
  logic [7:0]    mem_q;
  logic          wr2_pend;
  logic [AW-1:0] wr2_addr;

  logic          res_phase;
  logic          res_two;
  logic          res_echo0_valid;
  logic [7:0]    res_echo0_byte;
  logic [7:0]    res_echo1_byte;
  logic          res_eol;
  logic          res_read;
  logic          res_oob;
  logic          res_last;
  logic [CW+6:0] cnt_wide;

  assign res_last   = !res_two || res_phase;
  assign proc_fire  = s1_valid && (!result_valid || (result_ready && res_last));
  assign item_ready = !s1_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (proc_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1 <= item;
    end
  end

  assign count_p1        = {1'b0, count} + (CW + 1)'(1);
  assign status.nonempty = (count != '0);
  assign status.room1    = (count < CW'(LINE_CAPACITY));
  assign status.room2    = (count_p1 < (CW + 1)'(LINE_CAPACITY));

  sle_decode u_decode (
    .item   (s1),
    .status (status),
    .action (action)
  );

  always_comb begin
    count_next = count;
    if (action.clr) begin
      count_next = '0;
    end else if (action.dec) begin
      count_next = count - CW'(1);
    end else if (action.store1 && action.store2) begin
      count_next = count + CW'(2);
    end else if (action.store1) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wr2_pend <= 1'b0;
    end else begin
      wr2_pend <= proc_fire && action.store2;
      if (proc_fire) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      wr2_addr <= count_p1[AW-1:0];
    end
  end

  assign mem_we   = (proc_fire && action.store1) || wr2_pend;
  assign mem_wa   = wr2_pend ? wr2_addr : count[AW-1:0];
  assign mem_wd   = wr2_pend ? CHAR_LBRACKET : action.store_data;
  assign idx_wide = {{AW{1'b0}}, s1.read_index};
  assign rd_addr  = idx_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      mem_q <= line_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      res_phase    <= 1'b0;
    end else if (proc_fire) begin
      result_valid <= 1'b1;
      res_phase    <= 1'b0;
    end else if (result_valid && result_ready) begin
      if (res_last) begin
        result_valid <= 1'b0;
        res_phase    <= 1'b0;
      end else begin
        res_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      res_two         <= action.two;
      res_echo0_valid <= action.echo0_valid;
      res_echo0_byte  <= action.echo0_byte;
      res_echo1_byte  <= action.echo1_byte;
      res_eol         <= action.eol;
      res_read        <= action.is_read;
      res_oob         <= (32'(s1.read_index) >= LINE_CAPACITY);
    end
  end

  assign cnt_wide = {7'b0, count};

  always_comb begin
    result.echo_valid  = res_phase ? 1'b1 : res_echo0_valid;
    result.echo_byte   = res_phase ? res_echo1_byte : res_echo0_byte;
    result.end_of_line = res_eol;
    result.line_length = cnt_wide[6:0];
    result.read_data   = (res_read && !res_oob) ? mem_q : 8'h00;
    result.last        = res_last;
  end

  `SLE_ASSERT_ALWAYS(a_count_in_range, clk, rst, count <= CW'(LINE_CAPACITY), "count too large")
  `SLE_ASSERT_IMPLY(a_phase_two, clk, rst, res_phase, res_two && result_valid, "stray second word")
  `SLE_ASSERT_IMPLY(a_wr2_after_fire, clk, rst, wr2_pend, $past(proc_fire), "stray second write")
  `SLE_ASSERT_IMPLY(a_wr2_port_free, clk, rst, wr2_pend, !proc_fire, "write port used twice")

endmodule
